@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the polyphase decimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

@@ rtl/core/pfd_pkg.sv @@
// Package with sizes, coefficient table and stage bundles of the polyphase decimator.
package pfd_pkg;

  localparam int STAGES       = 5;
  localparam int PHASES       = 9;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 13;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int DOT_WIDTH    = PROD_WIDTH + $clog2(STAGES);
  localparam int ACC_WIDTH    = 40;
  localparam int PHASE_WIDTH  = $clog2(PHASES);
  localparam int ROWS         = STAGES - 1;

  typedef logic [PHASE_WIDTH-1:0]         phase_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [DOT_WIDTH-1:0]    dot_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;

  localparam phase_t PHASE_LAST = PHASE_WIDTH'(PHASES - 1);

  localparam coef_t COEF_TAB [STAGES][PHASES] = '{
    '{13'sd1883, 13'sd1700, 13'sd1518, 13'sd1338, 13'sd1163,
      13'sd994,  13'sd833,  13'sd680,  13'sd537},
    '{13'sd3244, 13'sd3140, 13'sd3021, 13'sd2887, 13'sd2740,
      13'sd2583, 13'sd2417, 13'sd2243, 13'sd2064},
    '{13'sd3331, 13'sd3400, 13'sd3449, 13'sd3479, 13'sd3489,
      13'sd3479, 13'sd3449, 13'sd3400, 13'sd3331},
    '{13'sd2064, 13'sd2243, 13'sd2417, 13'sd2583, 13'sd2740,
      13'sd2887, 13'sd3021, 13'sd3140, 13'sd3244},
    '{13'sd537,  13'sd680,  13'sd833,  13'sd994,  13'sd1163,
      13'sd1338, 13'sd1518, 13'sd1700, 13'sd1883}
  };

  typedef struct packed {
    logic                      valid;
    phase_t                    phase;
    logic [STAGES-1:0][SAMPLE_WIDTH-1:0] tap;
  } tap_bundle_t;

  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic [STAGES-1:0][PROD_WIDTH-1:0] prod;
  } prod_bundle_t;

endpackage

@@ rtl/core/pfd_delay_line.sv @@
// Phase counter, per-phase delay columns and registered tap read.
module pfd_delay_line
  import pfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        accept,
  input  sample_t     sample,
  output tap_bundle_t tap_q
);

  sample_t delay_store [ROWS][PHASES];
  phase_t  phase_count;
  phase_t  phase_count_next;

  assign phase_count_next = (phase_count == PHASE_LAST) ? '0 : phase_count + phase_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      tap_q.valid <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < PHASES; c++) begin
          delay_store[r][c] <= '0;
        end
      end
    end else if (en) begin
      tap_q.valid <= accept;
      if (accept) begin
        phase_count <= phase_count_next;
        tap_q.phase <= phase_count;
        for (int r = 0; r < ROWS; r++) begin
          tap_q.tap[r] <= delay_store[r][phase_count];
        end
        tap_q.tap[STAGES-1] <= sample;
        for (int r = 0; r < ROWS - 1; r++) begin
          delay_store[r][phase_count] <= delay_store[r+1][phase_count];
        end
        delay_store[ROWS-1][phase_count] <= sample;
      end
    end
  end

endmodule

@@ rtl/core/pfd_products.sv @@
// Tap by coefficient products for the current phase column.
module pfd_products
  import pfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  tap_bundle_t  tap_q,
  output prod_bundle_t prod_q
);

  prod_t prod [STAGES];

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      prod[k] = prod_t'($signed(tap_q.tap[k])) * prod_t'(COEF_TAB[k][tap_q.phase]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_q.valid <= 1'b0;
    end else if (en) begin
      prod_q.valid <= tap_q.valid;
      if (tap_q.valid) begin
        prod_q.last <= (tap_q.phase == PHASE_LAST);
        for (int k = 0; k < STAGES; k++) begin
          prod_q.prod[k] <= prod[k];
        end
      end
    end
  end

endmodule

@@ rtl/core/pfd_accum.sv @@
// Product sum, running phase accumulator and output register.
module pfd_accum
  import pfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  prod_bundle_t prod_q,
  input  logic         out_ready,
  output logic         out_valid,
  output acc_t         filtered,
  output logic         en
);

  dot_t dot;
  acc_t partial_sum;
  acc_t partial_sum_next;

  always_comb begin
    dot = '0;
    for (int k = 0; k < STAGES; k++) begin
      dot = dot + dot_t'($signed(prod_q.prod[k]));
    end
  end

  assign partial_sum_next = partial_sum + acc_t'(dot);
  assign en = !(prod_q.valid && prod_q.last && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (en && prod_q.valid) begin
        if (prod_q.last) begin
          partial_sum <= '0;
          out_valid   <= 1'b1;
        end else begin
          partial_sum <= partial_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && prod_q.valid && prod_q.last) begin
      filtered <= partial_sum_next;
    end
  end

endmodule

@@ rtl/core/polyphase_fir_decimator.sv @@
// 45-tap FIR decimate-by-9 filter in polyphase form, 5 stages by 9 phases.
// Takes one signed 16-bit sample per clock unless stalled and gives one 40-bit sum after
// every ninth sample; a result goes from the tap and product registers into the output
// register. The path is delay read, five parallel multiplies, then sum and accumulate,
// one register stage each. Input stalls only when a finished sum reaches the accumulator
// while the previous one still sits unread in the output register.
`include "assert_macros.svh"

module polyphase_fir_decimator
  import pfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [39:0] filtered
);

  logic         en;
  tap_bundle_t  tap_q;
  prod_bundle_t prod_q;
  acc_t         filtered;

  assign s_tready = en;
  assign m_tdata  = filtered;

  pfd_delay_line u_delay (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .accept (s_tvalid),
    .sample (sample_t'(s_tdata)),
    .tap_q  (tap_q)
  );

  pfd_products u_products (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .tap_q  (tap_q),
    .prod_q (prod_q)
  );

  pfd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .prod_q    (prod_q),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .filtered  (filtered),
    .en        (en)
  );

  `ASSERT_IMPLIES(a_stall_cause, clk, rst, !s_tready,
    m_tvalid && !m_tready && prod_q.valid && prod_q.last,
    "input stalled without a pending result")
  `ASSERT_IMPLIES(a_result_after_last, clk, rst, $rose(m_tvalid),
    $past(prod_q.valid && prod_q.last), "result without a last phase")
  `ASSERT_IMPLIES(a_phase_range, clk, rst, tap_q.valid, tap_q.phase <= PHASE_LAST,
    "phase out of range")
  `ASSERT_NEXT(a_hold_result, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "output word changed while waiting")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the polyphase FIR decimator, predicting every decimated sum.
`timescale 1ns / 100ps

module tb_top;

  localparam int FIR_STAGES  = 5;
  localparam int NUM_PHASES  = 9;
  localparam int LAST_PHASE  = NUM_PHASES - 1;
  localparam int IDLE_PCT    = 18;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;

  localparam int TAPS [FIR_STAGES][NUM_PHASES] = '{
    '{1883, 1700, 1518, 1338, 1163,  994,  833,  680,  537},
    '{3244, 3140, 3021, 2887, 2740, 2583, 2417, 2243, 2064},
    '{3331, 3400, 3449, 3479, 3489, 3479, 3449, 3400, 3331},
    '{2064, 2243, 2417, 2583, 2740, 2887, 3021, 3140, 3244},
    '{ 537,  680,  833,  994, 1163, 1338, 1518, 1700, 1883}
  };

  typedef enum {RUN_UNIFORM, RUN_FULL_POS, RUN_FULL_NEG, RUN_EXTREMES, RUN_SMALL} run_kind_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic [15:0]        pending_samples [$];
  logic signed [39:0] expected_sums [$];

  logic signed [15:0] history [FIR_STAGES-1][NUM_PHASES];
  int                 phase_idx;
  logic signed [39:0] running_sum;

  logic s_taken   = 1'b0;
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int cycle_count  = 0;
  int samples_in   = 0;
  int sums_checked = 0;
  int mismatches   = 0;

  polyphase_fir_decimator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic predict_sample(input logic [15:0] word);
    longint dot;
    int     p;
    dot = 0;
    p = (phase_idx >= NUM_PHASES) ? 0 : phase_idx;
    for (int k = 0; k < FIR_STAGES - 1; k++) begin
      dot += longint'(TAPS[k][p]) * longint'(history[k][p]);
    end
    dot += longint'(TAPS[FIR_STAGES-1][p]) * longint'($signed(word));
    for (int k = 0; k < FIR_STAGES - 2; k++) begin
      history[k][p] = history[k+1][p];
    end
    history[FIR_STAGES-2][p] = $signed(word);
    running_sum = running_sum + dot[39:0];
    if (p == LAST_PHASE) begin
      expected_sums.push_back(running_sum);
      running_sum = '0;
      phase_idx = 0;
    end else begin
      phase_idx = p + 1;
    end
  endtask

  task automatic queue_random_run(input int count);
    run_kind_t kind;
    logic [15:0] v;
    kind = RUN_UNIFORM;
    for (int i = 0; i < count; i++) begin
      if (i % (FIR_STAGES * NUM_PHASES) == 0) begin
        kind = run_kind_t'($urandom_range(RUN_SMALL));
      end
      case (kind)
        RUN_FULL_POS: v = SAMPLE_MAX;
        RUN_FULL_NEG: v = SAMPLE_MIN;
        RUN_EXTREMES: v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        RUN_SMALL:    v = 16'($urandom_range(8)) - 16'd4;
        default:      v = 16'($urandom);
      endcase
      pending_samples.push_back(v);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_tvalid || expected_sums.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // sample handshakes, predict and check
  always @(posedge clk) begin
    s_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_sample(s_tdata);
      samples_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %0d", $time,
                 $signed(m_tdata));
        mismatches++;
      end else begin
        if (m_tdata !== expected_sums[0]) begin
          $display("%0t: filtered mismatch, expected %0d, got %0d", $time,
                   expected_sums[0], $signed(m_tdata));
          mismatches++;
        end
        void'(expected_sums.pop_front());
        sums_checked++;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!s_tvalid || s_taken) begin
      if (!rst && pending_samples.size() != 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_samples.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d sums still expected", $time, expected_sums.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < FIR_STAGES - 1; k++) begin
      for (int p = 0; p < NUM_PHASES; p++) begin
        history[k][p] = '0;
      end
    end
    phase_idx   = 0;
    running_sum = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full-scale runs of each sign, then corner values
    for (int i = 0; i < NUM_PHASES; i++) pending_samples.push_back(SAMPLE_MAX);
    for (int i = 0; i < NUM_PHASES; i++) pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h5555);
    pending_samples.push_back(16'hAAAA);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    wait_drained();

    queue_random_run(450);
    wait_drained();

    calm = 1'b1;
    queue_random_run(300);
    wait_drained();
    calm = 1'b0;

    // stall the output long enough to back up the input
    hold_req = 1'b1;
    queue_random_run(300);
    wait_drained();

    queue_random_run(400);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Fed %0d samples (full-scale runs, corner values, random and small runs)",
             samples_in);
    $display("Checked %0d decimated sums under random stalls and a long output hold-off",
             sums_checked);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pfd_pkg.sv
rtl/core/pfd_delay_line.sv
rtl/core/pfd_products.sv
rtl/core/pfd_accum.sv
rtl/core/polyphase_fir_decimator.sv
sim/tb_top.sv
